// ----- hdl/ssdbs_pkg.sv -----
// shared types and constants of the spectrum level byte scaler
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package ssdbs_pkg;

    // default geometry
    localparam int NUM_BINS_DEF = 512;
    localparam int FFT_SIZE_DEF = 1024;

    // field widths
    localparam int IDX_W  = 9;
    localparam int SAMP_W = 24;
    localparam int MAG_W  = 24;
    localparam int LVL_W  = 8;
    localparam int DB_W   = 9;
    localparam int WGT_W  = 8;

    // register reset values
    localparam logic [WGT_W-1:0]        WGT_RST    = 8'd128;
    localparam logic signed [DB_W-1:0]  MIN_DB_RST = -9'sd100;
    localparam logic signed [DB_W-1:0]  MAX_DB_RST = -9'sd30;

    // 20*log10(2) in Q16
    localparam logic [18:0] DB_PER_OCT_Q16 = 19'd394566;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_WEIGHT = 2'd0,
        CFG_MIN_DB = 2'd1,
        CFG_MAX_DB = 2'd2
    } t_cfg_idx;

    // control travelling alongside each request
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic             zero_lvl;
    } t_tag;

    // square root recurrence state
    typedef struct packed {
        logic [63:0] v;
        logic [33:0] rem;
        logic [31:0] root;
    } t_sq;

endpackage

// ----- hdl/ssdbs_mag.sv -----
// bin magnitude: squares, sum, pipelined integer square root, scale and saturate
// depends on ssdbs_pkg
`timescale 1ns / 1ps

module ssdbs_mag import ssdbs_pkg::*; #(
    parameter int FFT_SIZE = FFT_SIZE_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  t_tag                     i_tag,
    input  logic signed [SAMP_W-1:0] i_re,
    input  logic signed [SAMP_W-1:0] i_im,
    output t_tag                     o_tag,
    output logic [MAG_W-1:0]         o_mag
);

    localparam int FLOG      = $clog2(FFT_SIZE);
    localparam int SQ_STAGES = 16;

    t_tag                     r_t0, r_t1, r_tm;
    t_tag                     r_ts [SQ_STAGES+1];
    logic signed [SAMP_W-1:0] r_re0, r_im0;
    logic [46:0]              r_sq_re, r_sq_im;
    t_sq                      r_sq [SQ_STAGES+1];
    logic [MAG_W-1:0]         r_mag;

    logic signed [47:0]       p_re, p_im;
    logic [47:0]              sum;
    logic [31:0]              shr;
    logic [MAG_W-1:0]         n_mag;
    logic signed [SAMP_W-1:0] n_im;

    // one bit of the root per step
    function automatic t_sq sq_step(input t_sq a);
        t_sq        b;
        logic [33:0] rm;
        logic [33:0] t;
        rm  = {a.rem[31:0], a.v[63:62]};
        t   = {a.root, 2'b01};
        b.v = {a.v[61:0], 2'b00};
        if (rm >= t) begin
            b.rem  = rm - t;
            b.root = {a.root[30:0], 1'b1};
        end else begin
            b.rem  = rm;
            b.root = {a.root[30:0], 1'b0};
        end
        return b;
    endfunction

    // bin zero has no imaginary part
    assign n_im = (i_tag.idx == '0) ? '0 : i_im;

    assign p_re = r_re0 * r_re0;
    assign p_im = r_im0 * r_im0;
    assign sum  = {1'b0, r_sq_re} + {1'b0, r_sq_im};

    // 2*root/FFT_SIZE with saturation to the q2.22 range
    assign shr   = r_sq[SQ_STAGES].root >> (FLOG - 1);
    assign n_mag = (shr > 32'h00FF_FFFF) ? '1 : shr[MAG_W-1:0];

    // control pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t0 <= '0;
            r_t1 <= '0;
            r_tm <= '0;
            for (int i = 0; i <= SQ_STAGES; i++) begin
                r_ts[i] <= '0;
            end
        end else if (i_en) begin
            r_t0    <= i_tag;
            r_t1    <= r_t0;
            r_ts[0] <= r_t1;
            for (int i = 1; i <= SQ_STAGES; i++) begin
                r_ts[i] <= r_ts[i-1];
            end
            r_tm <= r_ts[SQ_STAGES];
        end
    end

    // data pipeline
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_re0   <= i_re;
            r_im0   <= n_im;
            r_sq_re <= p_re[46:0];
            r_sq_im <= p_im[46:0];
            r_sq[0] <= '{v: {sum, 16'd0}, rem: 34'd0, root: 32'd0};
            for (int i = 1; i <= SQ_STAGES; i++) begin
                r_sq[i] <= sq_step(sq_step(r_sq[i-1]));
            end
            r_mag <= n_mag;
        end
    end

    assign o_tag = r_tm;
    assign o_mag = r_mag;

endmodule

// ----- hdl/ssdbs_blend.sv -----
// per-bin smoothing store with read-modify-write forwarding and clearing pass
// depends on ssdbs_pkg
`timescale 1ns / 1ps

module ssdbs_blend import ssdbs_pkg::*; #(
    parameter int NUM_BINS = NUM_BINS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_tag             i_tag,
    input  logic [MAG_W-1:0] i_mag,
    input  logic [WGT_W-1:0] i_weight,
    output t_tag             o_tag,
    output logic [MAG_W-1:0] o_smag,
    output logic             o_clearing
);

    localparam int AW = $clog2(NUM_BINS);
    localparam int XW = ((AW > IDX_W) ? AW : IDX_W) + 1;

    logic [MAG_W-1:0] r_mem [NUM_BINS];
    logic [MAG_W-1:0] r_rd;

    t_tag             r_b_tag, r_w_tag;
    logic             r_b_inr, r_w_inr, r_w2_ok;
    logic [AW-1:0]    r_b_addr, r_w_addr, r_w2_addr;
    logic [MAG_W-1:0] r_b_mag, r_w_val, r_w2_val;
    logic             r_clearing;
    logic [AW-1:0]    r_clr_addr;

    logic [XW-1:0]    in_x;
    logic             in_inr;
    logic [AW-1:0]    in_addr;
    logic [MAG_W-1:0] old;
    logic [8:0]       wn;
    logic [31:0]      p_old;
    logic [32:0]      p_new;
    logic [32:0]      bsum;
    t_tag             n_w_tag;

    // bin address and range check
    assign in_x    = XW'(i_tag.idx);
    assign in_inr  = in_x < XW'(NUM_BINS);
    assign in_addr = in_x[AW-1:0];

    // newest value of the bin: item ahead, item two ahead, else the store
    always_comb begin
        if (r_w_tag.valid && r_w_inr && (r_w_addr == r_b_addr)) begin
            old = r_w_val;
        end else if (r_w2_ok && (r_w2_addr == r_b_addr)) begin
            old = r_w2_val;
        end else begin
            old = r_rd;
        end
    end

    // weighted blend, weights sum to 256
    assign wn    = 9'd256 - {1'b0, i_weight};
    assign p_old = 32'(i_weight) * 32'(old);
    assign p_new = 33'(wn) * 33'(r_b_mag);
    assign bsum  = 33'(p_old) + p_new;

    always_comb begin
        n_w_tag          = r_b_tag;
        n_w_tag.zero_lvl = !r_b_inr;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_tag    <= '0;
            r_w_tag    <= '0;
            r_w2_ok    <= 1'b0;
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            if (i_en) begin
                r_b_tag <= i_tag;
                r_w_tag <= n_w_tag;
                r_w2_ok <= r_w_tag.valid && r_w_inr;
            end
            if (r_clearing) begin
                if (r_clr_addr == AW'(NUM_BINS - 1)) begin
                    r_clearing <= 1'b0;
                end else begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_inr   <= in_inr;
            r_b_addr  <= in_addr;
            r_b_mag   <= i_mag;
            r_w_inr   <= r_b_inr;
            r_w_addr  <= r_b_addr;
            r_w_val   <= bsum[31:8];
            r_w2_addr <= r_w_addr;
            r_w2_val  <= r_w_val;
        end
    end

    // store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_en && r_w_tag.valid && r_w_inr) begin
            r_mem[r_w_addr] <= r_w_val;
        end
        if (i_en) begin
            r_rd <= r_mem[in_addr];
        end
    end

    assign o_tag      = r_w_tag;
    assign o_smag     = r_w_val;
    assign o_clearing = r_clearing;

endmodule

// ----- hdl/ssdbs_log.sv -----
// log2 of the smoothed magnitude in q16: leading one, then sixteen squaring stages
// depends on ssdbs_pkg
`timescale 1ns / 1ps

module ssdbs_log import ssdbs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  t_tag               i_tag,
    input  logic [MAG_W-1:0]   i_s,
    output t_tag               o_tag,
    output logic signed [21:0] o_lq
);

    localparam int NSTG = 16;

    t_tag              r_tg [NSTG+1];
    logic [30:0]       r_m  [NSTG+1];
    logic [15:0]       r_f  [NSTG+1];
    logic signed [5:0] r_e  [NSTG+1];

    logic [4:0]        p;
    logic [53:0]       ext;
    t_tag              n_tag;

    // leading one position
    always_comb begin
        p = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (i_s[i]) begin
                p = 5'(i);
            end
        end
    end

    // mantissa normalised to q30
    assign ext = 54'(i_s) << (5'd30 - p);

    always_comb begin
        n_tag          = i_tag;
        n_tag.zero_lvl = i_tag.zero_lvl || (i_s == '0);
    end

    // control pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= NSTG; i++) begin
                r_tg[i] <= '0;
            end
        end else if (i_en) begin
            r_tg[0] <= n_tag;
            for (int i = 1; i <= NSTG; i++) begin
                r_tg[i] <= r_tg[i-1];
            end
        end
    end

    // squaring stages, one fraction bit each
    always_ff @(posedge i_clk) begin
        logic [61:0] sq;
        logic [31:0] sh;
        if (i_en) begin
            r_m[0] <= ext[30:0];
            r_f[0] <= '0;
            r_e[0] <= signed'(6'(p) - 6'd22);
            for (int i = 1; i <= NSTG; i++) begin
                sq = 62'(r_m[i-1]) * 62'(r_m[i-1]);
                sh = sq[61:30];
                if (sh[31]) begin
                    r_m[i] <= sh[31:1];
                    r_f[i] <= {r_f[i-1][14:0], 1'b1};
                end else begin
                    r_m[i] <= sh[30:0];
                    r_f[i] <= {r_f[i-1][14:0], 1'b0};
                end
                r_e[i] <= r_e[i-1];
            end
        end
    end

    assign o_tag = r_tg[NSTG];
    assign o_lq  = signed'({r_e[NSTG], r_f[NSTG]});

endmodule

// ----- hdl/ssdbs_scale.sv -----
// decibel conversion, linear map onto 0..255 with clamp; holds the output register
// depends on ssdbs_pkg
`timescale 1ns / 1ps

module ssdbs_scale import ssdbs_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  t_tag                   i_tag,
    input  logic signed [21:0]     i_lq,
    input  logic signed [DB_W-1:0] i_min_db,
    input  logic signed [DB_W-1:0] i_max_db,
    output t_tag                   o_tag,
    output logic [LVL_W-1:0]       o_level
);

    t_tag               r_t1, r_t2, r_t3, r_t4;
    logic signed [41:0] r_db;
    logic signed [42:0] r_d;
    logic [18:0]        r_nq;
    logic [8:0]         r_sp;
    logic               r_pos;
    logic [LVL_W-1:0]   r_level;

    logic signed [41:0] p_db;
    logic signed [42:0] n_d;
    logic [42:0]        ad;
    logic [50:0]        n255;
    logic signed [9:0]  span;
    logic [9:0]         span_abs;
    logic [8:0]         n_sp;
    logic               n_pos;
    logic [19:0]        rm;
    logic [LVL_W-1:0]   q;
    logic [LVL_W-1:0]   n_level;

    // db in q32
    assign p_db = i_lq * signed'({1'b0, DB_PER_OCT_Q16});

    // offset from the lower limit
    assign n_d = 43'(r_db) - (43'(i_min_db) <<< 32);

    // magnitude of 255*d over 2^32, span magnitude, sign of the quotient
    assign ad       = r_d[42] ? 43'(-r_d) : 43'(r_d);
    assign n255     = ({8'd0, ad} << 8) - {8'd0, ad};
    assign span     = 10'(i_max_db) - 10'(i_min_db);
    assign span_abs = span[9] ? 10'(-span) : 10'(span);
    assign n_sp     = (span == '0) ? 9'd1 : span_abs[8:0];
    assign n_pos    = (r_d != '0) && (r_d[42] == span[9]) && !r_t2.zero_lvl;

    // eight-bit restoring quotient, clamped at 255
    always_comb begin
        rm = 20'(r_nq);
        q  = '0;
        if (rm >= (20'(r_sp) << 8)) begin
            q = '1;
        end else begin
            for (int k = LVL_W - 1; k >= 0; k--) begin
                if (rm >= (20'(r_sp) << k)) begin
                    rm   = rm - (20'(r_sp) << k);
                    q[k] = 1'b1;
                end
            end
        end
        n_level = r_pos ? q : '0;
    end

    // control pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1 <= '0;
            r_t2 <= '0;
            r_t3 <= '0;
            r_t4 <= '0;
        end else if (i_en) begin
            r_t1 <= i_tag;
            r_t2 <= r_t1;
            r_t3 <= r_t2;
            r_t4 <= r_t3;
        end
    end

    // data pipeline
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_db    <= p_db;
            r_d     <= n_d;
            r_nq    <= n255[50:32];
            r_sp    <= n_sp;
            r_pos   <= n_pos;
            r_level <= n_level;
        end
    end

    assign o_tag   = r_t4;
    assign o_level = r_level;

endmodule

// ----- hdl/spectrum_smoothing_db_byte_scaler.sv -----
// spectrum level scaler: fft bin in, smoothed decibel byte out
// one request per cycle while no result waits and no clearing pass runs
// the whole pipeline advances together and holds while the result waits
// after reset a clearing pass zeroes the bin store, input not ready
// reset: synchronous, active low; weight 128, limits -100 dB and -30 dB
`timescale 1ns / 1ps

module spectrum_smoothing_db_byte_scaler import ssdbs_pkg::*; #(
    parameter int NUM_BINS = NUM_BINS_DEF,
    parameter int FFT_SIZE = FFT_SIZE_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [IDX_W-1:0]         i_bin_index,
    input  logic signed [SAMP_W-1:0] i_bin_real,
    input  logic signed [SAMP_W-1:0] i_bin_imag,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [IDX_W-1:0]         o_out_index,
    output logic [LVL_W-1:0]         o_level,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [1:0]               i_cfg_index,
    input  logic [DB_W-1:0]          i_cfg_data
);

    logic [WGT_W-1:0]        r_weight;
    logic signed [DB_W-1:0]  r_min_db, r_max_db;

    logic             en;
    logic             clearing;
    t_tag             in_tag, mag_tag, bl_tag, log_tag, out_tag;
    logic [MAG_W-1:0] mag, smag;
    logic signed [21:0] lq;

    // global advance: output register empty or being taken
    assign en          = !o_out_valid || i_out_ready;
    assign o_in_ready  = en && !clearing;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        in_tag.valid    = i_in_valid && o_in_ready;
        in_tag.idx      = i_bin_index;
        in_tag.zero_lvl = 1'b0;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= WGT_RST;
            r_min_db <= MIN_DB_RST;
            r_max_db <= MAX_DB_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_WEIGHT: r_weight <= i_cfg_data[WGT_W-1:0];
                CFG_MIN_DB: r_min_db <= signed'(i_cfg_data);
                CFG_MAX_DB: r_max_db <= signed'(i_cfg_data);
                default: ;
            endcase
        end
    end

    ssdbs_mag #(
        .FFT_SIZE(FFT_SIZE)
    ) u_mag (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_tag   (in_tag),
        .i_re    (i_bin_real),
        .i_im    (i_bin_imag),
        .o_tag   (mag_tag),
        .o_mag   (mag)
    );

    ssdbs_blend #(
        .NUM_BINS(NUM_BINS)
    ) u_blend (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_tag      (mag_tag),
        .i_mag      (mag),
        .i_weight   (r_weight),
        .o_tag      (bl_tag),
        .o_smag     (smag),
        .o_clearing (clearing)
    );

    ssdbs_log u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_tag   (bl_tag),
        .i_s     (smag),
        .o_tag   (log_tag),
        .o_lq    (lq)
    );

    ssdbs_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_tag    (log_tag),
        .i_lq     (lq),
        .i_min_db (r_min_db),
        .i_max_db (r_max_db),
        .o_tag    (out_tag),
        .o_level  (o_level)
    );

    assign o_out_valid = out_tag.valid;
    assign o_out_index = out_tag.idx;

    // no request taken while the store is being cleared
    a_no_accept_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !o_in_ready)
        else $error("request accepted during clearing pass");

    // bins beyond the store always give level zero
    a_out_of_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && ({1'b0, o_out_index} >= (IDX_W+1)'(NUM_BINS))) |-> (o_level == '0))
        else $error("nonzero level for bin beyond store");

    // pipeline empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

// ----- verif/spectrum_smoothing_db_byte_scaler_test.sv -----
// testbench for the spectrum level byte scaler: random and directed bins, checked
// against an in-bench predictor of the smoothed magnitude store and the dB mapping
// depends on ssdbs_pkg and spectrum_smoothing_db_byte_scaler
`timescale 1ns / 1ps

module spectrum_smoothing_db_byte_scaler_test;
    import ssdbs_pkg::*;

    localparam longint Q32 = 64'sd4294967296;
    localparam int LIMIT_CYCLES = 300000;

    typedef struct {
        logic [IDX_W-1:0]         idx;
        logic signed [SAMP_W-1:0] re;
        logic signed [SAMP_W-1:0] im;
    } t_bin;

    typedef struct {
        logic [IDX_W-1:0] idx;
        logic [LVL_W-1:0] level;
    } t_level;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     o_in_ready;
    logic [IDX_W-1:0]         bin_index = '0;
    logic signed [SAMP_W-1:0] bin_real = '0;
    logic signed [SAMP_W-1:0] bin_imag = '0;
    logic                     o_out_valid;
    logic                     out_ready = 1'b0;
    logic [IDX_W-1:0]         o_out_index;
    logic [LVL_W-1:0]         o_level;
    logic                     cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    t_cfg_idx                 cfg_index = CFG_WEIGHT;
    logic [DB_W-1:0]          cfg_data = '0;

    // predictor state
    logic [MAG_W-1:0] mag_store [NUM_BINS_DEF];
    int               weight = 128;
    int               lo_db = -100;
    int               hi_db = -30;

    t_bin   pending_bins[$];
    t_level expected_levels[$];
    int     errors = 0;
    int     cycles = 0;
    bit     no_gaps = 1'b0;
    bit     long_hold_req = 1'b0;

    spectrum_smoothing_db_byte_scaler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_bin_index (bin_index),
        .i_bin_real  (bin_real),
        .i_bin_imag  (bin_imag),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_index (o_out_index),
        .o_level     (o_level),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] x;
        r = 0;
        b = 64'h1 << 62;
        x = v;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // log2 of a Q2.22 value, Q16 result, fraction by repeated squaring
    function automatic longint log2_q16(input logic [MAG_W-1:0] s);
        int          p;
        logic [63:0] m;
        longint      frac;
        p = 23;
        frac = 0;
        while (p > 0 && s[p] == 1'b0) p--;
        m = 64'(s) << (30 - p);
        for (int k = 15; k >= 0; k--) begin
            m = (m * m) >> 30;
            if (m >= 64'h8000_0000) begin
                m = m >> 1;
                frac += longint'(1) << k;
            end
        end
        return longint'(p - 22) * 65536 + frac;
    endfunction

    // smoothed magnitude update and decibel byte for one bin
    function automatic logic [LVL_W-1:0] smooth_and_scale(input t_bin b);
        longint      re;
        longint      im;
        logic [63:0] mag;
        logic [63:0] blend;
        longint      db;
        longint      num;
        longint      den;
        longint      q;
        re = b.re;
        im = (b.idx == 0) ? 0 : b.im;
        mag = (isqrt(64'(re * re + im * im) << 16) * 2) / FFT_SIZE_DEF;
        if (mag > 64'hFF_FFFF) mag = 64'hFF_FFFF;
        blend = (64'(weight) * mag_store[b.idx] + 64'(256 - weight) * mag) >> 8;
        if (blend > 64'hFF_FFFF) blend = 64'hFF_FFFF;
        mag_store[b.idx] = blend[MAG_W-1:0];
        if (blend == 0)
            db = longint'(lo_db) * Q32;
        else
            db = log2_q16(blend[MAG_W-1:0]) * longint'(DB_PER_OCT_Q16);
        num = 255 * (db - longint'(lo_db) * Q32);
        den = (hi_db == lo_db) ? Q32 : longint'(hi_db - lo_db) * Q32;
        q = num / den;
        if (q > 255) q = 255;
        if (q < 0) q = 0;
        return q[LVL_W-1:0];
    endfunction

    // append a bin to the queue of pending requests
    task automatic add_bin(input t_bin b);
        pending_bins.insert(pending_bins.size(), b);
    endtask

    // request driver
    always @(posedge i_clk) begin
        t_bin cur;
        t_bin got;
        static int gap_left = 0;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                got.idx = bin_index;
                got.re = bin_real;
                got.im = bin_imag;
                expected_levels.insert(expected_levels.size(),
                                       '{got.idx, smooth_and_scale(got)});
                gap_left = no_gaps ? 0 : $urandom_range(0, 3);
            end
            if (!(in_valid && !o_in_ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_bins.size() > 0) begin
                    cur = pending_bins.pop_front();
                    bin_index <= cur.idx;
                    bin_real <= cur.re;
                    bin_imag <= cur.im;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin
        t_level exp_lvl;
        static int stall_left = 0;
        static int hold_left = 0;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (expected_levels.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result idx %0d level %0d",
                             $time, o_out_index, o_level);
                end else begin
                    exp_lvl = expected_levels.pop_front();
                    if (o_out_index !== exp_lvl.idx) begin
                        errors++;
                        $display("%0t: out_index expected %0d actual %0d",
                                 $time, exp_lvl.idx, o_out_index);
                    end
                    if (o_level !== exp_lvl.level) begin
                        errors++;
                        $display("%0t: level (bin %0d) expected %0d actual %0d",
                                 $time, exp_lvl.idx, exp_lvl.level, o_level);
                    end
                end
                stall_left = no_gaps ? 0 : $urandom_range(0, 3);
            end
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("spectrum_smoothing_db_byte_scaler_test: errors");
            $finish;
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input int value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[DB_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_WEIGHT: weight = value & 8'hFF;
            CFG_MIN_DB: lo_db = $signed(value[DB_W-1:0]);
            CFG_MAX_DB: hi_db = $signed(value[DB_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        do begin
            @(posedge i_clk);
            #1;
        end while (pending_bins.size() > 0 || in_valid || expected_levels.size() > 0);
        repeat (50) @(posedge i_clk);
    endtask

    function automatic t_bin random_bin();
        t_bin        b;
        logic [31:0] r;
        int          sh;
        r = $urandom;
        sh = $urandom_range(0, 23);
        b.idx = IDX_W'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 15)
                                                  : $urandom_range(0, 511));
        b.re = $signed(r[23:0]) >>> sh;
        r = $urandom;
        sh = $urandom_range(0, 23);
        b.im = $signed(r[23:0]) >>> sh;
        if ($urandom_range(0, 9) == 0) begin
            b.re = '0;
            b.im = '0;
        end
        return b;
    endfunction

    task automatic queue_random(input int n);
        repeat (n) add_bin(random_bin());
    endtask

    initial begin
        for (int i = 0; i < NUM_BINS_DEF; i++) mag_store[i] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings, extremes, bin 0 imaginary ignored, smoothing repeats
        add_bin('{9'd0, 24'sd0, 24'sd0});
        add_bin('{9'd0, 24'sd1000, -24'sd8388608});
        add_bin('{9'd1, -24'sd8388608, -24'sd8388608});
        add_bin('{9'd1, -24'sd8388608, -24'sd8388608});
        add_bin('{9'd2, 24'sd8388607, 24'sd8388607});
        add_bin('{9'd511, 24'sd8388607, -24'sd8388608});
        add_bin('{9'd511, 24'sd0, 24'sd0});
        add_bin('{9'd3, 24'sd1, 24'sd0});
        add_bin('{9'd3, 24'sd0, -24'sd1});
        add_bin('{9'd256, 24'sd8192, 24'sd8192});
        add_bin('{9'd255, -24'sd1, 24'sd1});
        add_bin('{9'd0, -24'sd8388608, 24'sd8388607});
        wait_drained();

        // weight extremes and wide limits
        write_reg(CFG_WEIGHT, 0);
        write_reg(CFG_MIN_DB, -160);
        write_reg(CFG_MAX_DB, 0);
        add_bin('{9'd1, 24'sd1, 24'sd0});
        add_bin('{9'd2, -24'sd8388608, 24'sd0});
        no_gaps = 1'b1;
        queue_random(150);
        wait_drained();
        no_gaps = 1'b0;

        write_reg(CFG_WEIGHT, 255);
        write_reg(CFG_MIN_DB, -90);
        write_reg(CFG_MAX_DB, -10);
        queue_random(80);
        // receiver holds off while the sender keeps offering
        #1 long_hold_req = 1'b1;
        queue_random(80);
        wait_drained();

        // equal limits
        write_reg(CFG_WEIGHT, $urandom_range(0, 255));
        write_reg(CFG_MIN_DB, -60);
        write_reg(CFG_MAX_DB, -60);
        add_bin('{9'd9, 24'sd0, 24'sd0});
        queue_random(150);
        wait_drained();

        // reversed limits, and an ignored write to the unused index
        write_reg(CFG_MIN_DB, -20);
        write_reg(CFG_MAX_DB, -120);
        write_reg(t_cfg_idx'(2'd3), 9'h1FF);
        queue_random(150);
        wait_drained();

        // both limits at the bottom, then at the top
        write_reg(CFG_WEIGHT, 1);
        write_reg(CFG_MIN_DB, -160);
        write_reg(CFG_MAX_DB, -160);
        queue_random(80);
        wait_drained();
        write_reg(CFG_MIN_DB, 0);
        write_reg(CFG_MAX_DB, 0);
        queue_random(80);
        wait_drained();

        // back to the power-on settings
        write_reg(CFG_WEIGHT, 128);
        write_reg(CFG_MIN_DB, -100);
        write_reg(CFG_MAX_DB, -30);
        queue_random(180);
        wait_drained();

        if (errors == 0) begin
            $display("spectrum_smoothing_db_byte_scaler_test: clean");
        end else begin
            $display("spectrum_smoothing_db_byte_scaler_test: errors");
        end
        $finish;
    end

endmodule
